// ----- rtl/ulbp_pkg.sv -----
`timescale 1ns / 1ps
package ulbp_pkg;

	localparam int unsigned PIX_W        = 8;
	localparam int unsigned DIM_W        = 12;
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned MAX_WIDTH    = 2048;
	localparam int unsigned MAX_HEIGHT   = 2048;
	localparam int unsigned MIN_DIM      = 3;
	localparam int unsigned RESET_WIDTH  = 640;
	localparam int unsigned RESET_HEIGHT = 480;
	localparam int unsigned UNIFORM_LIMIT = 2;
	localparam int unsigned QUEUE_DEPTH  = 4;
	localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [PIX_W-1:0] NON_UNIFORM = 8'd59;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	typedef logic [255:0][PIX_W-1:0] lbp_map_t;

	typedef struct packed {
		logic [PIX_W-1:0] px1;
		logic             code1;
		logic             two;
		logic [PIX_W-1:0] px2;
		logic             fe;
	} ulbp_entry_t;

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		int unsigned r;
		r = v;
		if (r < MIN_DIM) r = MIN_DIM;
		if (r > hi) r = hi;
		return r;
	endfunction

	function automatic lbp_map_t build_uniform_map();
		lbp_map_t    m;
		int unsigned idx;
		logic [7:0]  c;
		logic [7:0]  d;
		idx = 0;
		for (int i = 0; i < 256; i++) begin
			c = 8'(i);
			d = c ^ {c[0], c[7:1]};
			if ($countones(d) <= UNIFORM_LIMIT) begin
				m[i] = 8'(idx);
				idx++;
			end else begin
				m[i] = NON_UNIFORM;
			end
		end
		return m;
	endfunction

	localparam lbp_map_t UNIFORM_MAP = build_uniform_map();

endpackage

// ----- rtl/ulbp_pix_if.sv -----
`timescale 1ns / 1ps
interface ulbp_pix_if import ulbp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             kind;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, output kind, output pixel_in, input ready);
	modport sink (input valid, input kind, input pixel_in, output ready);
endinterface

// ----- rtl/ulbp_res_if.sv -----
`timescale 1ns / 1ps
interface ulbp_res_if import ulbp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             is_code;
	logic             frame_end;

	modport source (output valid, output pixel_out, output is_code, output frame_end,
		input ready);
	modport sink (input valid, input pixel_out, input is_code, input frame_end,
		output ready);
endinterface

// ----- rtl/ulbp_cfg_if.sv -----
`timescale 1ns / 1ps
interface ulbp_cfg_if import ulbp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/ulbp_ram.sv -----
`timescale 1ns / 1ps
module ulbp_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/ulbp_front.sv -----
`timescale 1ns / 1ps
module ulbp_front import ulbp_pkg::*; #(
	parameter int unsigned MAX_W = MAX_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	ulbp_pix_if.sink           pixels,
	ulbp_cfg_if.sink           cfg,
	input  logic [QCNT_W-1:0]  q_count,
	output logic               push,
	output ulbp_entry_t        push_entry
);
	localparam int unsigned XW = $clog2(MAX_W);

	logic [XW-1:0]    x_q;
	logic [DIM_W-1:0] y_q;
	logic [XW-1:0]    width_last_q;
	logic [DIM_W-1:0] height_q;

	logic             acc, drop, proc, flush_row;
	logic [PIX_W-1:0] p_in;
	logic [2*PIX_W-1:0] rd_data;

	logic             v_s1, has_s1, border_s1, two_s1, fe_s1;
	logic [XW-1:0]    x_s1;
	logic [PIX_W-1:0] p_s1;
	logic             v_s2, has_s2, border_s2, two_s2, fe_s2;
	logic [PIX_W-1:0] win_q [9];
	logic [7:0]       code;
	logic [QCNT_W-1:0] credit;

	assign credit = q_count + QCNT_W'(v_s1) + QCNT_W'(v_s2);
	assign pixels.ready = credit < QCNT_W'(QUEUE_DEPTH);
	assign cfg.ready = 1'b1;

	assign acc       = pixels.valid && pixels.ready;
	assign flush_row = (y_q == height_q);
	assign drop      = !flush_row && pixels.kind;
	assign proc      = acc && !drop;
	assign p_in      = flush_row ? '0 : pixels.pixel_in;

	// line store pair: upper byte middle row, lower byte upper row
	ulbp_ram #(.WIDTH(2 * PIX_W), .DEPTH(MAX_W)) u_lines (
		.clk   (clk),
		.we    (v_s1),
		.waddr (x_s1),
		.wdata ({p_s1, rd_data[2*PIX_W-1:PIX_W]}),
		.re    (proc),
		.raddr (x_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q          <= '0;
			y_q          <= '0;
			width_last_q <= XW'(clamp_dim(RESET_WIDTH, MAX_W) - 1);
			height_q     <= DIM_W'(clamp_dim(RESET_HEIGHT, MAX_HEIGHT));
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FRAME_WIDTH: begin
					width_last_q <= XW'(clamp_dim(32'(cfg.data), MAX_W) - 1);
					x_q <= '0;
					y_q <= '0;
				end
				REG_FRAME_HEIGHT: begin
					height_q <= DIM_W'(clamp_dim(32'(cfg.data), MAX_HEIGHT));
					x_q <= '0;
					y_q <= '0;
				end
				default: ;
			endcase
		end else if (proc) begin
			if (x_q == width_last_q) begin
				x_q <= '0;
				y_q <= flush_row ? '0 : y_q + 1'b1;
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= proc;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			x_s1      <= x_q;
			p_s1      <= p_in;
			has_s1    <= (y_q != '0) && (x_q != '0);
			border_s1 <= (x_q == XW'(1)) || (y_q == DIM_W'(1)) || flush_row;
			two_s1    <= (y_q != '0) && (x_q == width_last_q);
			fe_s1     <= flush_row;
		end
		has_s2    <= has_s1;
		border_s2 <= border_s1;
		two_s2    <= two_s1;
		fe_s2     <= fe_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else if (v_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]     <= win_q[r*3 + 1];
				win_q[r*3 + 1] <= win_q[r*3 + 2];
			end
			win_q[2] <= rd_data[PIX_W-1:0];
			win_q[5] <= rd_data[2*PIX_W-1:PIX_W];
			win_q[8] <= p_s1;
		end
	end

	// clockwise from top-left
	assign code = {win_q[0] >= win_q[4], win_q[1] >= win_q[4], win_q[2] >= win_q[4],
		win_q[5] >= win_q[4], win_q[8] >= win_q[4], win_q[7] >= win_q[4],
		win_q[6] >= win_q[4], win_q[3] >= win_q[4]};

	assign push             = v_s2 && has_s2;
	assign push_entry.px1   = border_s2 ? win_q[4] : UNIFORM_MAP[code];
	assign push_entry.code1 = !border_s2;
	assign push_entry.two   = two_s2;
	assign push_entry.px2   = win_q[5];
	assign push_entry.fe    = fe_s2;

	a_drop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && drop && !cfg.valid) |=> ($stable(x_q) && $stable(y_q)))
		else $error("flush inside frame moved the position");
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		credit <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue credit exceeded");
endmodule

// ----- rtl/ulbp_queue.sv -----
`timescale 1ns / 1ps
module ulbp_queue import ulbp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ulbp_entry_t       push_entry,
	input  logic              pop,
	output ulbp_entry_t       head,
	output logic              not_empty,
	output logic [QCNT_W-1:0] count
);
	localparam int unsigned PW = $clog2(QUEUE_DEPTH);

	ulbp_entry_t       slot_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_q, rd_q;
	logic [QCNT_W-1:0] count_q;

	assign head      = slot_q[rd_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_entry;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < QCNT_W'(QUEUE_DEPTH)))
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue underflow");
endmodule

// ----- rtl/ulbp_back.sv -----
`timescale 1ns / 1ps
module ulbp_back import ulbp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ulbp_entry_t head,
	input  logic        not_empty,
	output logic        pop,
	ulbp_res_if.source  results
);
	logic             out_valid_q, second_q;
	logic [PIX_W-1:0] px_q;
	logic             code_q, fe_q;
	logic             load;

	assign load = (!out_valid_q || results.ready) && not_empty;
	assign pop  = load && (second_q || !head.two);

	assign results.valid     = out_valid_q;
	assign results.pixel_out = px_q;
	assign results.is_code   = code_q;
	assign results.frame_end = fe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				second_q    <= !pop;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			px_q   <= second_q ? head.px2 : head.px1;
			code_q <= second_q ? 1'b0 : head.code1;
			fe_q   <= second_q ? head.fe : 1'b0;
		end
	end

	a_second_has_two: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> (not_empty && head.two))
		else $error("second result without a two-result request");
endmodule

// ----- rtl/uniform_lbp_3x3_pixel.sv -----
`timescale 1ns / 1ps
// path: the completing item goes through ram read, window stage, queue and output register
// throughput: one item per cycle when queue credit allows, one line-store ram read per item
// the row-end item yields two results below row 0; the next row-start item yields none
// reset: position to row 0 column 0, frame size 640 x 480, window zero
// line stores are not cleared, no clearing pass after reset
module uniform_lbp_3x3_pixel import ulbp_pkg::*; #(
	parameter int unsigned MAX_W = MAX_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	ulbp_pix_if.sink   pixels,
	ulbp_res_if.source results,
	ulbp_cfg_if.sink   cfg
);
	logic              push, pop, not_empty;
	ulbp_entry_t       push_entry, head;
	logic [QCNT_W-1:0] q_count;

	ulbp_front #(.MAX_W(MAX_W)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixels     (pixels),
		.cfg        (cfg),
		.q_count    (q_count),
		.push       (push),
		.push_entry (push_entry)
	);

	ulbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.not_empty  (not_empty),
		.count      (q_count)
	);

	ulbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.results   (results)
	);
endmodule
